/* rtl/core/ptts_pkg.sv */
`default_nettype none
package ptts_pkg;

	localparam int TASK_SLOTS_DEF = 8;
	localparam int FUNC_W         = 3;
	localparam int SLOT_W         = 3;
	localparam int TIME_W         = 16;
	localparam int MASK_W         = 8;

	localparam logic [FUNC_W-1:0] OP_TICK    = 3'd0;
	localparam logic [FUNC_W-1:0] OP_CREATE  = 3'd1;
	localparam logic [FUNC_W-1:0] OP_SUSPEND = 3'd2;
	localparam logic [FUNC_W-1:0] OP_RESUME  = 3'd3;
	localparam logic [FUNC_W-1:0] OP_DELETE  = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic apply_op;
		logic walk_start;
		logic walk_step;
		logic out_load;
		logic out_tick;
	} ptts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic last_issue;
	} ptts_sts_t;

endpackage
`default_nettype wire

/* rtl/core/ptts_ram.sv */
`default_nettype none
module ptts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/ptts_ctrl.sv */
`default_nettype none
module ptts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire ptts_pkg::ptts_sts_t sts,
	output ptts_pkg::ptts_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sts.is_tick) begin
						cmd.walk_start = 1'b1;
						state_nxt      = S_WALK;
					end else begin
						cmd.apply_op = 1'b1;
						cmd.out_load = 1'b1;
					end
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.last_issue) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_tick = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/ptts_dp.sv */
`default_nettype none
module ptts_dp #(
	parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [ptts_pkg::FUNC_W-1:0]   func,
	input  wire logic [ptts_pkg::SLOT_W-1:0]   slot,
	input  wire logic [ptts_pkg::TIME_W-1:0]   period,
	input  wire logic [ptts_pkg::TIME_W-1:0]   first_delay,
	output logic      [ptts_pkg::MASK_W-1:0]   fired_mask,
	output logic                               create_status,
	input  wire ptts_pkg::ptts_cmd_t           cmd,
	output ptts_pkg::ptts_sts_t                sts
);

	localparam int SW    = TASK_SLOTS > 1 ? $clog2(TASK_SLOTS) : 1;
	localparam int WALKN = TASK_SLOTS < ptts_pkg::MASK_W ? TASK_SLOTS : ptts_pkg::MASK_W;

	logic [TASK_SLOTS-1:0]         valid_q;
	logic [TASK_SLOTS-1:0]         susp_q;
	logic [SW-1:0]                 rd_idx_q;
	logic                          go_s1;
	logic [SW-1:0]                 idx_s1;
	logic [ptts_pkg::MASK_W-1:0]   mask_q;
	logic [ptts_pkg::MASK_W-1:0]   fired_q;
	logic                          status_q;

	logic [SW-1:0]                 sidx;
	logic                          in_range;
	logic                          do_create;
	logic                          op_status;
	logic                          act;
	logic                          cd_zero;
	logic [ptts_pkg::TIME_W-1:0]   cd_rdata;
	logic [ptts_pkg::TIME_W-1:0]   per_rdata;
	logic [ptts_pkg::TIME_W-1:0]   cd_next;
	logic                          cd_we;
	logic [SW-1:0]                 cd_waddr;
	logic [ptts_pkg::TIME_W-1:0]   cd_wdata;

	assign sidx      = SW'(slot);
	assign in_range  = 32'(slot) < TASK_SLOTS;
	assign op_status = in_range && (func == ptts_pkg::OP_CREATE) && valid_q[sidx];
	assign do_create = cmd.apply_op && in_range && (func == ptts_pkg::OP_CREATE)
		&& !valid_q[sidx];

	assign sts.is_tick    = (func == ptts_pkg::OP_TICK);
	assign sts.last_issue = (rd_idx_q == SW'(WALKN - 1));

	// slot walk, one slot per cycle behind the memory read
	assign act     = go_s1 && valid_q[idx_s1] && !susp_q[idx_s1];
	assign cd_zero = (cd_rdata == '0);
	assign cd_next = cd_zero ? per_rdata - 1'b1 : cd_rdata - 1'b1;

	assign cd_we    = do_create || act;
	assign cd_waddr = do_create ? sidx : idx_s1;
	assign cd_wdata = do_create ? first_delay : cd_next;

	ptts_ram #(
		.WIDTH(ptts_pkg::TIME_W),
		.DEPTH(TASK_SLOTS)
	) u_countdown (
		.clk    (clk),
		.we     (cd_we),
		.waddr  (cd_waddr),
		.wdata  (cd_wdata),
		.raddr  (rd_idx_q),
		.rdata_q(cd_rdata)
	);

	ptts_ram #(
		.WIDTH(ptts_pkg::TIME_W),
		.DEPTH(TASK_SLOTS)
	) u_period (
		.clk    (clk),
		.we     (do_create),
		.waddr  (sidx),
		.wdata  (period),
		.raddr  (rd_idx_q),
		.rdata_q(per_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			susp_q   <= '0;
			rd_idx_q <= '0;
			go_s1    <= 1'b0;
		end else begin
			go_s1 <= cmd.walk_step;
			if (cmd.walk_start) begin
				rd_idx_q <= '0;
			end else if (cmd.walk_step) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.apply_op && in_range) begin
				case (func)
					ptts_pkg::OP_CREATE: begin
						if (!valid_q[sidx]) begin
							valid_q[sidx] <= 1'b1;
							susp_q[sidx]  <= 1'b0;
						end
					end
					ptts_pkg::OP_SUSPEND: begin
						susp_q[sidx] <= 1'b1;
					end
					ptts_pkg::OP_RESUME: begin
						susp_q[sidx] <= 1'b0;
					end
					ptts_pkg::OP_DELETE: begin
						valid_q[sidx] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (cmd.walk_start) begin
			mask_q <= '0;
		end else if (act && cd_zero) begin
			mask_q <= mask_q | (ptts_pkg::MASK_W'(1) << idx_s1);
		end
		if (cmd.out_load) begin
			if (cmd.out_tick) begin
				fired_q  <= mask_q;
				status_q <= 1'b0;
			end else begin
				fired_q  <= '0;
				status_q <= op_status;
			end
		end
	end

	assign fired_mask    = fired_q;
	assign create_status = status_q;

endmodule
`default_nettype wire

/* rtl/core/periodic_task_tick_scheduler.sv */
`default_nettype none
// Periodic task scheduler over TASK_SLOTS slots.
// Each request returns exactly one response. Create, suspend, resume and delete
// complete in the accept cycle and their response is presented on the next cycle.
// A tick walks the addressable slots (min(TASK_SLOTS, 8)) one per cycle through
// the single read port of the countdown and period memories, then passes a flush
// state and loads its response once the response register is free. In idle, a new
// request is taken while an older response still waits, provided the response
// register is free or being emptied in that cycle. No clearing pass is needed
// after reset.
module periodic_task_tick_scheduler #(
	parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [ptts_pkg::FUNC_W-1:0] func,
	input  wire logic [ptts_pkg::SLOT_W-1:0] slot,
	input  wire logic [ptts_pkg::TIME_W-1:0] period,
	input  wire logic [ptts_pkg::TIME_W-1:0] first_delay,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [ptts_pkg::MASK_W-1:0] fired_mask,
	output logic                             create_status
);

	ptts_pkg::ptts_cmd_t cmd;
	ptts_pkg::ptts_sts_t sts;

	ptts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptts_dp #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.func         (func),
		.slot         (slot),
		.period       (period),
		.first_delay  (first_delay),
		.fired_mask   (fired_mask),
		.create_status(create_status),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire
